/* rtl/cvkp_pkg.sv */
package cvkp_pkg;

    // Fixed-point format of the state and the step interval.
    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;

    // Covariance store: upper triangle of the 4x4 matrix, row by row.
    localparam int NUM_COV = 10;
    localparam int ENT_W   = 4;

    // Configuration port address width (four word registers).
    localparam int CFG_AW = 4;

    // Input operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Memory read selection.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_AB,
        RD_COWN
    } t_rd;

    // Multiplier operand source.
    typedef enum logic [1:0] {
        SUM_NONE,
        SUM_AB,
        SUM_VX,
        SUM_VY
    } t_sum;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_FULL,
        ACC_MEAN
    } t_acc;

    // Result write-back target.
    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_COV,
        UPD_X,
        UPD_Y,
        UPD_LMEAN,
        UPD_LOAD
    } t_upd;

    // Entry counter operation.
    typedef enum logic [1:0] {
        ENT_KEEP,
        ENT_CLR,
        ENT_INC
    } t_ent;

    // Program flow.
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOAD,
        JMP_LOOP,
        JMP_EMIT
    } t_jmp;

    // One microcode word.
    typedef struct packed {
        t_rd              rd;
        t_sum             sum;
        logic             mul_en;
        logic             dd_en;
        t_acc             acc;
        t_upd             upd;
        t_ent             ent;
        t_jmp             jmp;
        logic [4:0]       target;
        logic [ENT_W-1:0] ent_last;
    } t_ctrl;

endpackage

/* rtl/cvkp_cfg.sv */
module cvkp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cvkp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [15:0]                 o_dt,
    output logic signed [31:0]          o_vel_x,
    output logic signed [31:0]          o_vel_y,
    output logic [30:0]                 o_noise
);
    import cvkp_pkg::*;

    localparam logic [1:0] REG_DT    = 2'd0;
    localparam logic [1:0] REG_VEL_X = 2'd1;
    localparam logic [1:0] REG_VEL_Y = 2'd2;
    localparam logic [1:0] REG_NOISE = 2'd3;

    logic [15:0]        r_dt;
    logic signed [31:0] r_vel_x;
    logic signed [31:0] r_vel_y;
    logic [30:0]        r_noise;
    logic [1:0]         w_idx;
    logic               w_wr;

    assign w_idx  = paddr[CFG_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes during the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= 16'd655;
            r_vel_x <= 32'sd32768;
            r_vel_y <= 32'sd32768;
            r_noise <= 31'd65536;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DT:    r_dt    <= pwdata[15:0];
                REG_VEL_X: r_vel_x <= $signed(pwdata);
                REG_VEL_Y: r_vel_y <= $signed(pwdata);
                REG_NOISE: r_noise <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_idx)
            REG_DT:    prdata = {16'd0, r_dt};
            REG_VEL_X: prdata = r_vel_x;
            REG_VEL_Y: prdata = r_vel_y;
            REG_NOISE: prdata = {1'b0, r_noise};
            default:   prdata = '0;
        endcase
    end

    assign o_dt    = r_dt;
    assign o_vel_x = r_vel_x;
    assign o_vel_y = r_vel_y;
    assign o_noise = r_noise;

endmodule

/* rtl/cvkp_seq.sv */
module cvkp_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_operation,
    input  logic                       i_out_free,
    output logic                       o_in_ready,
    output logic                       o_capture,
    output logic                       o_emit,
    output cvkp_pkg::t_ctrl            o_ctrl,
    output logic [cvkp_pkg::ENT_W-1:0] o_ent
);
    import cvkp_pkg::*;

    localparam int PC_W = 5;

    // Program map.
    localparam logic [PC_W-1:0] PC_DISPATCH = 5'd0;
    localparam logic [PC_W-1:0] PC_X_SUM    = 5'd1;
    localparam logic [PC_W-1:0] PC_X_MUL    = 5'd2;
    localparam logic [PC_W-1:0] PC_X_ACC    = 5'd3;
    localparam logic [PC_W-1:0] PC_X_UPD    = 5'd4;
    localparam logic [PC_W-1:0] PC_Y_MUL    = 5'd5;
    localparam logic [PC_W-1:0] PC_Y_ACC    = 5'd6;
    localparam logic [PC_W-1:0] PC_Y_UPD    = 5'd7;
    localparam logic [PC_W-1:0] PC_BODY     = 5'd8;
    localparam logic [PC_W-1:0] PC_B_SUM    = 5'd9;
    localparam logic [PC_W-1:0] PC_B_MUL    = 5'd10;
    localparam logic [PC_W-1:0] PC_B_ACC    = 5'd11;
    localparam logic [PC_W-1:0] PC_B_UPD    = 5'd12;
    localparam logic [PC_W-1:0] PC_S_EMIT   = 5'd13;
    localparam logic [PC_W-1:0] PC_LOAD     = 5'd14;
    localparam logic [PC_W-1:0] PC_L_WR     = 5'd15;
    localparam logic [PC_W-1:0] PC_L_EMIT   = 5'd16;

    localparam logic [ENT_W-1:0] COV_LAST  = ENT_W'(8);
    localparam logic [ENT_W-1:0] LOAD_LAST = ENT_W'(NUM_COV - 1);

    // Microcode ROM.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '0;
        unique case (pc)
            PC_DISPATCH: begin
                w.dd_en  = 1'b1;
                w.ent    = ENT_CLR;
                w.jmp    = JMP_LOAD;
                w.target = PC_LOAD;
            end
            PC_X_SUM: w.sum = SUM_VX;
            PC_X_MUL: w.mul_en = 1'b1;
            PC_X_ACC: w.acc = ACC_MEAN;
            PC_X_UPD: begin
                w.upd = UPD_X;
                w.sum = SUM_VY;
            end
            PC_Y_MUL: w.mul_en = 1'b1;
            PC_Y_ACC: w.acc = ACC_MEAN;
            PC_Y_UPD: w.upd = UPD_Y;
            PC_BODY:  w.rd = RD_AB;
            PC_B_SUM: begin
                w.sum = SUM_AB;
                w.rd  = RD_COWN;
            end
            PC_B_MUL: w.mul_en = 1'b1;
            PC_B_ACC: w.acc = ACC_FULL;
            PC_B_UPD: begin
                w.upd      = UPD_COV;
                w.ent      = ENT_INC;
                w.jmp      = JMP_LOOP;
                w.target   = PC_BODY;
                w.ent_last = COV_LAST;
            end
            PC_S_EMIT: w.jmp = JMP_EMIT;
            PC_LOAD:   w.upd = UPD_LMEAN;
            PC_L_WR: begin
                w.upd      = UPD_LOAD;
                w.ent      = ENT_INC;
                w.jmp      = JMP_LOOP;
                w.target   = PC_L_WR;
                w.ent_last = LOAD_LAST;
            end
            PC_L_EMIT: w.jmp = JMP_EMIT;
            default:   w.jmp = JMP_EMIT;
        endcase
        return w;
    endfunction

    logic             r_busy;
    logic             r_op;
    logic [PC_W-1:0]  r_pc;
    logic [ENT_W-1:0] r_ent;
    t_ctrl            w_ctrl;

    assign w_ctrl     = r_busy ? ucode(r_pc) : '0;
    assign o_ctrl     = w_ctrl;
    assign o_ent      = r_ent;
    assign o_in_ready = !r_busy;
    assign o_capture  = i_in_valid && !r_busy;
    assign o_emit     = r_busy && (w_ctrl.jmp == JMP_EMIT) && i_out_free;

    // Busy flag, program counter, conditional jumps and entry counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= OP_LOAD;
            r_pc   <= PC_DISPATCH;
            r_ent  <= '0;
        end else if (o_capture) begin
            r_busy <= 1'b1;
            r_op   <= i_operation;
            r_pc   <= PC_DISPATCH;
        end else if (r_busy) begin
            unique case (w_ctrl.jmp)
                JMP_NEXT: r_pc <= r_pc + PC_W'(1);
                JMP_LOAD: r_pc <= (r_op == OP_LOAD) ? w_ctrl.target : r_pc + PC_W'(1);
                JMP_LOOP: r_pc <= (r_ent != w_ctrl.ent_last) ? w_ctrl.target
                                                               : r_pc + PC_W'(1);
                JMP_EMIT: begin
                    if (i_out_free) begin
                        r_busy <= 1'b0;
                    end
                end
                default: r_pc <= r_pc;
            endcase
            unique case (w_ctrl.ent)
                ENT_CLR:  r_ent <= '0;
                ENT_INC:  r_ent <= r_ent + ENT_W'(1);
                default:  r_ent <= r_ent;
            endcase
        end
    end

endmodule

/* rtl/cvkp_dp.sv */
module cvkp_dp #(
    parameter int FRAC_BITS = cvkp_pkg::FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cvkp_pkg::t_ctrl            i_ctrl,
    input  logic [cvkp_pkg::ENT_W-1:0] i_ent,
    input  logic                       i_capture,
    input  logic                       i_emit,
    output logic                       o_out_free,
    input  logic [15:0]                i_dt,
    input  logic signed [31:0]         i_vel_x,
    input  logic signed [31:0]         i_vel_y,
    input  logic [30:0]                i_noise,
    input  logic signed [31:0]         i_start_x,
    input  logic signed [31:0]         i_start_y,
    input  logic [30:0]                i_start_var_xx,
    input  logic [30:0]                i_start_var_yy,
    input  logic signed [31:0]         i_start_cov_xy,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [31:0]         o_pred_x,
    output logic signed [31:0]         o_pred_y,
    output logic [30:0]                o_pred_var_xx,
    output logic signed [31:0]         o_pred_cov_xy,
    output logic [30:0]                o_pred_var_yy,
    output logic                       o_saturated
);
    import cvkp_pkg::*;

    localparam int P1_W  = 50;
    localparam int P2_W  = 64;
    localparam int ACC_W = 51;
    localparam int INC_W = ACC_W - DT_BITS;
    localparam int V_W   = 37;

    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (DT_BITS - 1);
    localparam logic signed [V_W-1:0]   V_MAX = 37'sd2147483647;
    localparam logic signed [V_W-1:0]   V_MIN = -37'sd2147483648;
    localparam logic [31:0]             ONE   = 32'(1) << FRAC_BITS;

    // Covariance store addresses (upper triangle, row by row).
    localparam logic [ENT_W-1:0] A00 = 4'd0;
    localparam logic [ENT_W-1:0] A01 = 4'd1;
    localparam logic [ENT_W-1:0] A02 = 4'd2;
    localparam logic [ENT_W-1:0] A03 = 4'd3;
    localparam logic [ENT_W-1:0] A11 = 4'd4;
    localparam logic [ENT_W-1:0] A12 = 4'd5;
    localparam logic [ENT_W-1:0] A13 = 4'd6;
    localparam logic [ENT_W-1:0] A22 = 4'd7;
    localparam logic [ENT_W-1:0] A23 = 4'd8;
    localparam logic [ENT_W-1:0] A33 = 4'd9;

    typedef struct packed {
        logic [ENT_W-1:0] own;
        logic [ENT_W-1:0] a;
        logic             a_use;
        logic [ENT_W-1:0] b;
        logic             b_use;
        logic [ENT_W-1:0] c;
        logic             c_use;
        logic             diag;
    } t_desc;

    // Update order for the covariance loop. Every entry is rewritten only after
    // all entries that read its old value, so the store is updated in place.
    function automatic t_desc desc(input logic [ENT_W-1:0] e);
        t_desc d;
        d = '0;
        unique case (e)
            4'd0: d = '{own: A00, a: A01, a_use: 1'b1, b: A01, b_use: 1'b1,
                        c: A11, c_use: 1'b1, diag: 1'b1};
            4'd1: d = '{own: A01, a: A11, a_use: 1'b1, b: A00, b_use: 1'b0,
                        c: A00, c_use: 1'b0, diag: 1'b0};
            4'd2: d = '{own: A02, a: A12, a_use: 1'b1, b: A03, b_use: 1'b1,
                        c: A13, c_use: 1'b1, diag: 1'b0};
            4'd3: d = '{own: A03, a: A13, a_use: 1'b1, b: A00, b_use: 1'b0,
                        c: A00, c_use: 1'b0, diag: 1'b0};
            4'd4: d = '{own: A12, a: A00, a_use: 1'b0, b: A13, b_use: 1'b1,
                        c: A00, c_use: 1'b0, diag: 1'b0};
            4'd5: d = '{own: A22, a: A23, a_use: 1'b1, b: A23, b_use: 1'b1,
                        c: A33, c_use: 1'b1, diag: 1'b1};
            4'd6: d = '{own: A23, a: A33, a_use: 1'b1, b: A00, b_use: 1'b0,
                        c: A00, c_use: 1'b0, diag: 1'b0};
            4'd7: d = '{own: A11, a: A00, a_use: 1'b0, b: A00, b_use: 1'b0,
                        c: A00, c_use: 1'b0, diag: 1'b1};
            4'd8: d = '{own: A33, a: A00, a_use: 1'b0, b: A00, b_use: 1'b0,
                        c: A00, c_use: 1'b0, diag: 1'b1};
            default: d = '0;
        endcase
        return d;
    endfunction

    logic signed [31:0]      r_mem [NUM_COV];
    logic [NUM_COV-1:0]      r_valid;
    logic signed [31:0]      r_rda;
    logic signed [31:0]      r_rdb;
    logic signed [32:0]      r_sum;
    logic [31:0]             r_dd;
    logic signed [P1_W-1:0]  r_p1;
    logic signed [P2_W-1:0]  r_p2;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_x;
    logic signed [31:0]      r_vx;
    logic signed [31:0]      r_y;
    logic signed [31:0]      r_vy;
    logic [30:0]             r_cur_vxx;
    logic signed [31:0]      r_cur_cxy;
    logic [30:0]             r_cur_vyy;
    logic                    r_sat;
    logic signed [31:0]      r_sx;
    logic signed [31:0]      r_sy;
    logic [30:0]             r_sxx;
    logic [30:0]             r_syy;
    logic signed [31:0]      r_scxy;
    logic                    r_o_valid;
    logic signed [31:0]      r_o_x;
    logic signed [31:0]      r_o_y;
    logic [30:0]             r_o_vxx;
    logic signed [31:0]      r_o_cxy;
    logic [30:0]             r_o_vyy;
    logic                    r_o_sat;

    t_desc                   w_desc;
    logic signed [16:0]      w_dt_s;
    logic signed [INC_W-1:0] w_inc;
    logic signed [31:0]      w_base;
    logic                    w_diag;
    logic signed [V_W-1:0]   w_q;
    logic signed [V_W-1:0]   w_v;
    logic signed [V_W-1:0]   w_lo;
    logic                    w_lo_clip;
    logic                    w_hi_clip;
    logic signed [31:0]      w_res;
    logic                    w_clip_en;
    logic                    w_we;
    logic [ENT_W-1:0]        w_waddr;
    logic signed [31:0]      w_wdata;
    logic signed [31:0]      w_load_val;

    assign w_desc = desc(i_ent);
    assign w_dt_s = $signed({1'b0, i_dt});

    // Write-back: add the rounded increment (and q on the diagonal), then clip.
    assign w_inc  = $signed(r_acc[ACC_W-1:DT_BITS]);
    assign w_diag = (i_ctrl.upd == UPD_COV) && w_desc.diag;
    assign w_q    = w_diag ? $signed({6'd0, i_noise}) : '0;

    always_comb begin
        case (i_ctrl.upd)
            UPD_COV: w_base = r_rdb;
            UPD_X:   w_base = r_x;
            UPD_Y:   w_base = r_y;
            default: w_base = '0;
        endcase
    end

    assign w_v       = V_W'(w_base) + V_W'(w_inc) + w_q;
    assign w_lo      = w_diag ? '0 : V_MIN;
    assign w_lo_clip = w_v < w_lo;
    assign w_hi_clip = w_v > V_MAX;
    assign w_res     = w_lo_clip ? w_lo[31:0] : (w_hi_clip ? V_MAX[31:0] : w_v[31:0]);
    assign w_clip_en = (i_ctrl.upd == UPD_COV) || (i_ctrl.upd == UPD_X) ||
                       (i_ctrl.upd == UPD_Y);

    // Start values of the covariance on a load.
    always_comb begin
        case (i_ent) inside
            A00:      w_load_val = $signed({1'b0, r_sxx});
            A02:      w_load_val = r_scxy;
            A22:      w_load_val = $signed({1'b0, r_syy});
            A11, A33: w_load_val = $signed(ONE);
            default:  w_load_val = '0;
        endcase
    end

    assign w_we    = (i_ctrl.upd == UPD_COV) || (i_ctrl.upd == UPD_LOAD);
    assign w_waddr = (i_ctrl.upd == UPD_COV) ? w_desc.own : i_ent;
    assign w_wdata = (i_ctrl.upd == UPD_COV) ? w_res : w_load_val;

    // Covariance memory with registered reads; unwritten entries read as zero.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        case (i_ctrl.rd)
            RD_AB: begin
                r_rda <= (w_desc.a_use && r_valid[w_desc.a]) ? r_mem[w_desc.a] : '0;
                r_rdb <= (w_desc.b_use && r_valid[w_desc.b]) ? r_mem[w_desc.b] : '0;
            end
            RD_COWN: begin
                r_rda <= (w_desc.c_use && r_valid[w_desc.c]) ? r_mem[w_desc.c] : '0;
                r_rdb <= r_valid[w_desc.own] ? r_mem[w_desc.own] : '0;
            end
            default: ;
        endcase
    end

    // Arithmetic pipeline: operand sum, two multipliers, accumulator.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.dd_en) begin
            r_dd <= {16'd0, i_dt} * {16'd0, i_dt};
        end
        case (i_ctrl.sum)
            SUM_AB:  r_sum <= 33'(r_rda) + 33'(r_rdb);
            SUM_VX:  r_sum <= 33'(r_vx);
            SUM_VY:  r_sum <= 33'(r_vy);
            default: ;
        endcase
        if (i_ctrl.mul_en) begin
            r_p1 <= P1_W'(w_dt_s) * P1_W'(r_sum);
            r_p2 <= P2_W'($signed({1'b0, r_dd})) * P2_W'(r_rda);
        end
        case (i_ctrl.acc)
            ACC_FULL: r_acc <= ACC_W'(r_p1) + ACC_W'($signed(r_p2[P2_W-1:DT_BITS])) + HALF;
            ACC_MEAN: r_acc <= ACC_W'(r_p1) + HALF;
            default: ;
        endcase
    end

    // Captured input beat, the latest values of the reported entries and the output register.
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_sxx  <= i_start_var_xx;
            r_syy  <= i_start_var_yy;
            r_scxy <= i_start_cov_xy;
        end
        if (w_we && (w_waddr == A00)) begin
            r_cur_vxx <= w_wdata[30:0];
        end
        if (w_we && (w_waddr == A02)) begin
            r_cur_cxy <= w_wdata;
        end
        if (w_we && (w_waddr == A22)) begin
            r_cur_vyy <= w_wdata[30:0];
        end
        if (i_emit) begin
            r_o_x   <= r_x;
            r_o_y   <= r_y;
            r_o_vxx <= r_cur_vxx;
            r_o_cxy <= r_cur_cxy;
            r_o_vyy <= r_cur_vyy;
            r_o_sat <= r_sat;
        end
    end

    // Mean state, valid bits, saturation flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_x       <= '0;
            r_vx      <= '0;
            r_y       <= '0;
            r_vy      <= '0;
            r_sat     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            case (i_ctrl.upd)
                UPD_X: r_x <= w_res;
                UPD_Y: r_y <= w_res;
                UPD_LMEAN: begin
                    r_x  <= r_sx;
                    r_vx <= i_vel_x;
                    r_y  <= r_sy;
                    r_vy <= i_vel_y;
                end
                default: ;
            endcase
            if (i_capture) begin
                r_sat <= 1'b0;
            end else if (w_clip_en && (w_lo_clip || w_hi_clip)) begin
                r_sat <= 1'b1;
            end
            if (i_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_free    = !r_o_valid || i_out_ready;
    assign o_out_valid   = r_o_valid;
    assign o_pred_x      = r_o_x;
    assign o_pred_y      = r_o_y;
    assign o_pred_var_xx = r_o_vxx;
    assign o_pred_cov_xy = r_o_cxy;
    assign o_pred_var_yy = r_o_vyy;
    assign o_saturated   = r_o_sat;

endmodule

/* rtl/constant_velocity_kalman_predict_top.sv */
// Two-dimensional constant-velocity Kalman predictor, signed Q16.16 state
// [x, vx, y, vy] with a symmetric 4x4 covariance. A load beat (operation 0)
// sets the start mean and covariance; a step beat (operation 1) first moves
// the two positions and then runs the microcode loop that updates nine
// covariance entries through one shared pair of multipliers and a two-read-port
// covariance memory. One beat is in work at a time; the next is accepted in the
// cycle after the result is registered, even while that result still waits on
// i_out_ready. Every beat yields exactly one result beat. Configuration must be
// written by the user over the APB port only while the block is idle; the block
// itself does not enforce this.
module constant_velocity_kalman_predict_top #(
    parameter int FRAC_BITS = cvkp_pkg::FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cvkp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic signed [31:0]          i_start_x,
    input  logic signed [31:0]          i_start_y,
    input  logic [30:0]                 i_start_var_xx,
    input  logic [30:0]                 i_start_var_yy,
    input  logic signed [31:0]          i_start_cov_xy,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [31:0]          o_pred_x,
    output logic signed [31:0]          o_pred_y,
    output logic [30:0]                 o_pred_var_xx,
    output logic signed [31:0]          o_pred_cov_xy,
    output logic [30:0]                 o_pred_var_yy,
    output logic                        o_saturated
);
    import cvkp_pkg::*;

    logic [15:0]        w_dt;
    logic signed [31:0] w_vel_x;
    logic signed [31:0] w_vel_y;
    logic [30:0]        w_noise;
    t_ctrl              w_ctrl;
    logic [ENT_W-1:0]   w_ent;
    logic               w_capture;
    logic               w_emit;
    logic               w_out_free;

    // Configuration registers.
    cvkp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dt    (w_dt),
        .o_vel_x (w_vel_x),
        .o_vel_y (w_vel_y),
        .o_noise (w_noise)
    );

    // Microcode sequencer.
    cvkp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_free  (w_out_free),
        .o_in_ready  (o_in_ready),
        .o_capture   (w_capture),
        .o_emit      (w_emit),
        .o_ctrl      (w_ctrl),
        .o_ent       (w_ent)
    );

    // Datapath with covariance memory and output register.
    cvkp_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_ent          (w_ent),
        .i_capture      (w_capture),
        .i_emit         (w_emit),
        .o_out_free     (w_out_free),
        .i_dt           (w_dt),
        .i_vel_x        (w_vel_x),
        .i_vel_y        (w_vel_y),
        .i_noise        (w_noise),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_start_var_xx (i_start_var_xx),
        .i_start_var_yy (i_start_var_yy),
        .i_start_cov_xy (i_start_cov_xy),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pred_x       (o_pred_x),
        .o_pred_y       (o_pred_y),
        .o_pred_var_xx  (o_pred_var_xx),
        .o_pred_cov_xy  (o_pred_cov_xy),
        .o_pred_var_yy  (o_pred_var_yy),
        .o_saturated    (o_saturated)
    );

endmodule

/* rtl/cvkp_chk.sv */
module cvkp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_pred_x,
    input logic signed [31:0] o_pred_y,
    input logic [30:0]        o_pred_var_xx,
    input logic signed [31:0] o_pred_cov_xy,
    input logic [30:0]        o_pred_var_yy,
    input logic               o_saturated
);

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

    // An accepted beat keeps the input side closed while it is worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a beat is in work");

    // A new result only ever comes out of a beat that was in work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a beat in work");

    // A result beat that is not taken stays put.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_pred_x) && $stable(o_pred_y) &&
             $stable(o_pred_var_xx) && $stable(o_pred_cov_xy) &&
             $stable(o_pred_var_yy) && $stable(o_saturated)))
        else $error("stalled result beat changed");

endmodule

bind constant_velocity_kalman_predict_top cvkp_chk u_cvkp_chk (.*);

/* sim/cvkp_test_pkg.sv */
`timescale 1ns / 100ps

package cvkp_test_pkg;

    // Configuration registers in address order; byte address is index times four.
    typedef enum logic [1:0] {
        REG_STEP_INTERVAL,
        REG_VELOCITY_X,
        REG_VELOCITY_Y,
        REG_PROCESS_NOISE
    } t_reg_idx;

endpackage

/* sim/cvkp_estimate_checker.sv */
`timescale 1ns / 100ps

module cvkp_estimate_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [cvkp_pkg::CFG_AW-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic [31:0]                 i_prdata,
    input  logic                        i_pready,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_operation,
    input  logic signed [31:0]          i_start_x,
    input  logic signed [31:0]          i_start_y,
    input  logic [30:0]                 i_start_var_xx,
    input  logic [30:0]                 i_start_var_yy,
    input  logic signed [31:0]          i_start_cov_xy,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [31:0]          i_pred_x,
    input  logic signed [31:0]          i_pred_y,
    input  logic [30:0]                 i_pred_var_xx,
    input  logic signed [31:0]          i_pred_cov_xy,
    input  logic [30:0]                 i_pred_var_yy,
    input  logic                        i_saturated,
    output int                          o_fail_count,
    output int                          o_pending
);

    import cvkp_test_pkg::*;

    localparam longint S32_MIN  = -64'sd2147483648;
    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint HALF_LSB = longint'(1) << (cvkp_pkg::DT_BITS - 1);
    localparam logic signed [31:0] UNIT_VAR = 32'sd1 <<< cvkp_pkg::FRAC_BITS;

    // One predicted output beat.
    typedef struct packed {
        logic signed [31:0] pred_x;
        logic signed [31:0] pred_y;
        logic [30:0]        var_xx;
        logic signed [31:0] cov_xy;
        logic [30:0]        var_yy;
        logic               saturated;
    } t_estimate;

    // Shadow copy of the registers and the filter state.
    logic [15:0]        cfg_dt;
    logic signed [31:0] cfg_vx;
    logic signed [31:0] cfg_vy;
    logic [30:0]        cfg_q;
    logic signed [31:0] track_mean [4];
    logic signed [31:0] track_cov [10];

    t_estimate expected_estimates [$];
    int fault_count = 0;

    // Position of covariance entry (r, c) in the packed upper triangle.
    function automatic int cov_slot(int r, int c);
        int lo;
        int hi;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        case (lo)
            0:       return hi;
            1:       return 3 + hi;
            2:       return 5 + hi;
            default: return 9;
        endcase
    endfunction

    function automatic longint cov_at(int r, int c);
        return longint'(track_cov[cov_slot(r, c)]);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [31:0] reg_value(t_reg_idx idx);
        case (idx)
            REG_STEP_INTERVAL: return {16'h0, cfg_dt};
            REG_VELOCITY_X:    return cfg_vx;
            REG_VELOCITY_Y:    return cfg_vy;
            default:           return {1'b0, cfg_q};
        endcase
    endfunction

    // Apply one load or step beat to the shadow state and return the estimate.
    function automatic t_estimate apply_item(logic op, logic signed [31:0] sx,
                                             logic signed [31:0] sy, logic [30:0] svxx,
                                             logic [30:0] svyy, logic signed [31:0] scxy);
        t_estimate est;
        longint    d;
        longint    a;
        longint    b;
        longint    c;
        longint    inc;
        longint    v;
        longint    w;
        longint    fresh [10];
        bit        clipped;
        int        i;
        int        j;
        int        k;
        clipped = 1'b0;
        d = longint'(cfg_dt);
        if (op == cvkp_pkg::OP_LOAD) begin
            track_mean[0] = sx;
            track_mean[1] = cfg_vx;
            track_mean[2] = sy;
            track_mean[3] = cfg_vy;
            for (k = 0; k < 10; k++) track_cov[k] = '0;
            track_cov[cov_slot(0, 0)] = {1'b0, svxx};
            track_cov[cov_slot(2, 2)] = {1'b0, svyy};
            track_cov[cov_slot(0, 2)] = scxy;
            track_cov[cov_slot(1, 1)] = UNIT_VAR;
            track_cov[cov_slot(3, 3)] = UNIT_VAR;
        end else begin
            // Positions move by the rounded velocity times the interval.
            for (k = 0; k < 4; k += 2) begin
                inc = (longint'(track_mean[k + 1]) * d + HALF_LSB) >>> cvkp_pkg::DT_BITS;
                v = longint'(track_mean[k]) + inc;
                w = clamp(v, S32_MIN, S32_MAX);
                clipped |= (w != v);
                track_mean[k] = w[31:0];
            end
            // Covariance A*P*A^T + q*I, every entry from the old matrix.
            for (i = 0; i < 4; i++) begin
                for (j = i; j < 4; j++) begin
                    a = (i % 2 == 0) ? cov_at(i + 1, j) : 0;
                    b = (j % 2 == 0) ? cov_at(i, j + 1) : 0;
                    c = (i % 2 == 0 && j % 2 == 0) ? cov_at(i + 1, j + 1) : 0;
                    inc = (d * (a + b) + ((d * d * c) >>> cvkp_pkg::DT_BITS) + HALF_LSB)
                          >>> cvkp_pkg::DT_BITS;
                    v = cov_at(i, j) + inc;
                    if (i == j) begin
                        v = v + longint'(cfg_q);
                        w = clamp(v, 0, S32_MAX);
                    end else begin
                        w = clamp(v, S32_MIN, S32_MAX);
                    end
                    clipped |= (w != v);
                    fresh[cov_slot(i, j)] = w;
                end
            end
            for (k = 0; k < 10; k++) track_cov[k] = fresh[k][31:0];
        end
        est.pred_x    = track_mean[0];
        est.pred_y    = track_mean[2];
        est.var_xx    = track_cov[cov_slot(0, 0)][30:0];
        est.cov_xy    = track_cov[cov_slot(0, 2)];
        est.var_yy    = track_cov[cov_slot(2, 2)][30:0];
        est.saturated = clipped;
        return est;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Watch every handshake at the clock edge and keep the prediction in step.
    always @(posedge i_clk) begin : watch
        t_estimate want;
        if (!i_rst_n) begin
            cfg_dt = 16'd655;
            cfg_vx = 32'sd32768;
            cfg_vy = 32'sd32768;
            cfg_q  = 31'd65536;
            for (int k = 0; k < 4; k++) track_mean[k] = '0;
            for (int k = 0; k < 10; k++) track_cov[k] = '0;
            expected_estimates.delete();
        end else begin
            // Register access on the configuration port.
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[cvkp_pkg::CFG_AW-1:2]))
                        REG_STEP_INTERVAL: cfg_dt = i_pwdata[15:0];
                        REG_VELOCITY_X:    cfg_vx = i_pwdata;
                        REG_VELOCITY_Y:    cfg_vy = i_pwdata;
                        default:           cfg_q  = i_pwdata[30:0];
                    endcase
                end else begin
                    check_field("register read",
                                reg_value(t_reg_idx'(i_paddr[cvkp_pkg::CFG_AW-1:2])),
                                i_prdata);
                end
            end
            // Result beats are matched before this edge's input beat is queued.
            if (i_out_valid && i_out_ready) begin
                if (expected_estimates.size() == 0) begin
                    $display("%0t: result beat with no estimate pending, x %h y %h",
                             $time, i_pred_x, i_pred_y);
                    fault_count++;
                end else begin
                    want = expected_estimates.pop_front();
                    check_field("pred_x", want.pred_x, i_pred_x);
                    check_field("pred_y", want.pred_y, i_pred_y);
                    check_field("pred_var_xx", want.var_xx, i_pred_var_xx);
                    check_field("pred_cov_xy", want.cov_xy, i_pred_cov_xy);
                    check_field("pred_var_yy", want.var_yy, i_pred_var_yy);
                    check_field("saturated", want.saturated, i_saturated);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_estimates = {expected_estimates,
                                      apply_item(i_operation, i_start_x, i_start_y,
                                                 i_start_var_xx, i_start_var_yy,
                                                 i_start_cov_xy)};
            end
        end
        o_pending    <= expected_estimates.size();
        o_fail_count <= fault_count;
    end

endmodule

/* sim/constant_velocity_kalman_predict_top_test.sv */
`timescale 1ns / 100ps

module constant_velocity_kalman_predict_top_test;

    import cvkp_test_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int STEP_LATENCY = 60;
    localparam int SEG_ITEMS    = 60;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        psel           = 1'b0;
    logic                        penable        = 1'b0;
    logic                        pwrite         = 1'b0;
    logic [cvkp_pkg::CFG_AW-1:0] paddr          = '0;
    logic [31:0]                 pwdata         = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic                        i_operation    = 1'b0;
    logic signed [31:0]          i_start_x      = '0;
    logic signed [31:0]          i_start_y      = '0;
    logic [30:0]                 i_start_var_xx = '0;
    logic [30:0]                 i_start_var_yy = '0;
    logic signed [31:0]          i_start_cov_xy = '0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic signed [31:0]          o_pred_x;
    logic signed [31:0]          o_pred_y;
    logic [30:0]                 o_pred_var_xx;
    logic signed [31:0]          o_pred_cov_xy;
    logic [30:0]                 o_pred_var_yy;
    logic                        o_saturated;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int config_count  = 0;

    constant_velocity_kalman_predict_top dut (
        .i_clk, .i_rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in_valid, .o_in_ready,
        .i_operation, .i_start_x, .i_start_y,
        .i_start_var_xx, .i_start_var_yy, .i_start_cov_xy,
        .o_out_valid, .i_out_ready,
        .o_pred_x, .o_pred_y, .o_pred_var_xx, .o_pred_cov_xy, .o_pred_var_yy,
        .o_saturated
    );

    cvkp_estimate_checker u_estimate_check (
        .i_clk, .i_rst_n,
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_prdata(prdata), .i_pready(pready),
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_operation, .i_start_x, .i_start_y,
        .i_start_var_xx, .i_start_var_yy, .i_start_cov_xy,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_pred_x(o_pred_x), .i_pred_y(o_pred_y), .i_pred_var_xx(o_pred_var_xx),
        .i_pred_cov_xy(o_pred_cov_xy), .i_pred_var_yy(o_pred_var_yy),
        .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // 2 ns clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) results_seen <= results_seen + 1;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d idle cycles at %0t", quiet_cycles, $time);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        logic [31:0] mag;
        case ($urandom_range(9)) inside
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            [3:5]:   return $urandom;
            default: begin
                mag = $urandom_range(0, 32'h0010_0000);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [30:0] pick_var();
        case ($urandom_range(5))
            0:       return 31'h7fff_ffff;
            1:       return 31'h0;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0040_0000));
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(4))
            0:       return 16'hffff;
            1:       return 16'h0;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 2000));
        endcase
    endfunction

    task automatic set_pace(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // One input beat; valid stays up between back-to-back beats.
    task automatic send_item(input logic op, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic [30:0] vxx,
                             input logic [30:0] vyy, input logic signed [31:0] cxy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_start_x      <= x;
        i_start_y      <= y;
        i_start_var_xx <= vxx;
        i_start_var_yy <= vyy;
        i_start_cov_xy <= cxy;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_load(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic [30:0] vxx, input logic [30:0] vyy,
                             input logic signed [31:0] cxy);
        send_item(cvkp_pkg::OP_LOAD, x, y, vxx, vyy, cxy);
    endtask

    // Step payload is ignored by the block, so it carries random bits.
    task automatic send_step();
        send_item(cvkp_pkg::OP_STEP, $urandom, $urandom, 31'($urandom), 31'($urandom),
                  $urandom);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // APB setup and access cycle, then the bus returns to idle.
    task automatic apb_access(input logic wr, input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_all();
        for (int k = 0; k < 4; k++) apb_access(1'b0, t_reg_idx'(k), 32'h0);
    endtask

    task automatic set_config(input logic [15:0] dt, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [30:0] q);
        drain(4);
        apb_access(1'b1, REG_STEP_INTERVAL, {16'h0, dt});
        apb_access(1'b1, REG_VELOCITY_X, vx);
        apb_access(1'b1, REG_VELOCITY_Y, vy);
        apb_access(1'b1, REG_PROCESS_NOISE, {1'b0, q});
        read_all();
        config_count++;
    endtask

    initial begin
        int seg;
        int seg_start;
        int roll;
        int run_len;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_all();
        set_pace(21, 56);

        // Directed part, reset settings: step on the zero state, then a normal load.
        send_step();
        send_step();
        send_load(32'sh0001_0000, 32'shfffd_8000, 31'h0002_0000, 31'h0000_8000,
                  32'shffff_c000);
        repeat (3) send_step();
        // Largest start values so the first step clips.
        send_load(32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff, 31'h7fff_ffff,
                  32'sh7fff_ffff);
        send_step();

        // Longest interval, extreme velocities and noise.
        set_config(16'hffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
        send_load(32'sh8000_0000, 32'sh7fff_ffff, 31'h0, 31'h0, 32'sh8000_0000);
        send_step();
        send_step();

        // Zero interval and zero noise leave the state unchanged.
        set_config(16'h0, 32'h0, 32'h0, 31'h0);
        send_load(32'sh0, 32'sh0, 31'h0, 31'h0, 32'sh0);
        send_step();
        send_load(32'shffff_ffff, 32'sh0000_0001, 31'h1, 31'h1, 32'shffff_ffff);
        send_step();

        // Rounding of tiny negative and exactly-half increments.
        set_config(16'h1, 32'hffff_ffff, 32'h0000_8000, 31'h1);
        send_load(32'sh0, 32'sh0, 31'h0000_0100, 31'h0000_0100, 32'sh0000_0010);
        send_step();
        send_step();

        // Half-second interval with a negative velocity just above minus one.
        set_config(16'h8000, 32'hffff_0001, 32'h7fff_ffff, 31'h0001_0000);
        send_load(32'sh1234_5678, 32'shedcb_a988, 31'h0055_aaaa, 31'h2aaa_5555,
                  32'sha5a5_5a5a);
        send_step();
        send_step();

        // Random part: mostly load followed by a run of steps, some noise.
        for (seg = 0; seg < 6; seg++) begin
            if (seg == 2) set_pace(56, 21);
            if (seg == 4) set_pace(0, 0);
            set_config(pick_dt(), pick_word(), pick_word(), pick_var());
            seg_start = items_sent;
            while (items_sent - seg_start < SEG_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 80) begin
                    send_load(pick_word(), pick_word(), pick_var(), pick_var(), pick_word());
                    run_len = $urandom_range(1, 10);
                    repeat (run_len) send_step();
                end else if (roll < 90) begin
                    run_len = $urandom_range(1, 5);
                    repeat (run_len) send_step();
                end else begin
                    send_item(1'($urandom_range(1)), $urandom, $urandom, 31'($urandom),
                              31'($urandom), $urandom);
                end
            end
        end

        drain(STEP_LATENCY);

        $display("Covered %0d load and step beats, %0d result beats compared, over %0d",
                 items_sent, results_seen, config_count);
        $display("register settings, with each side stalling in turn and then full rate.");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* constant_velocity_kalman_predict_top.f */
rtl/cvkp_pkg.sv
rtl/cvkp_cfg.sv
rtl/cvkp_seq.sv
rtl/cvkp_dp.sv
rtl/constant_velocity_kalman_predict_top.sv
rtl/cvkp_chk.sv
sim/cvkp_test_pkg.sv
sim/cvkp_estimate_checker.sv
sim/constant_velocity_kalman_predict_top_test.sv
